// File: rtl/ir_integer_alu_core_defines.svh
// ----------------------------------------------------------------------------
// ir_integer_alu_core_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef IR_INTEGER_ALU_CORE_DEFINES_SVH
`define IR_INTEGER_ALU_CORE_DEFINES_SVH

// Property that holds whenever reset is released.
`define IRALU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property that also covers the cycles while reset is applied.
`define IRALU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/iralu_pkg.sv
// ----------------------------------------------------------------------------
// iralu_pkg
// Types, codes and helper functions of the integer ALU core.
// ----------------------------------------------------------------------------
package iralu_pkg;

    localparam int DATA_WIDTH_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [63:0] LOW32_MASK = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [4:0] {
        OP_MOVE, OP_ADD, OP_SUB, OP_XOR, OP_AND, OP_OR, OP_SHL, OP_UCARRY,
        OP_SCARRY, OP_TRUNC, OP_PARITY, OP_EQ, OP_NOT, OP_NEG, OP_SHR, OP_SAR,
        OP_ULESS, OP_SLESS, OP_CJUMP, OP_SEXT, OP_ZEXT, OP_SMUL, OP_SMULOVF,
        OP_UMUL, OP_UDIV, OP_SDIV, OP_SREM, OP_WDIV, OP_WREM, OP_UREM,
        OP_CNEG, OP_WMUL
    } op_e;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SIZE  = 3'd1,
        ST_DIV0  = 3'd2,
        ST_COND  = 3'd3,
        ST_BADOP = 3'd4
    } status_e;

    typedef enum logic [1:0] {
        K_SIMPLE,
        K_MUL,
        K_DIV
    } kind_e;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_MUL,
        BE_DIV
    } be_state_e;

    typedef struct packed {
        logic [4:0]  action;
        logic [1:0]  src_size;
        logic [1:0]  dst_size;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
        logic [63:0] operand_c;
    } in_t;

    typedef struct packed {
        logic [63:0] result_value;
        logic [63:0] result_upper;
        logic        take_jump;
        logic [2:0]  status;
    } out_t;

    // Classified word as it travels from front to back
    typedef struct packed {
        op_e         op;
        logic [1:0]  ss;
        logic [1:0]  ds;
        status_e     st;
        kind_e       kind;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] sa;
        logic [63:0] sb;
    } dec_t;

    typedef struct packed {
        logic start;
        logic ack;
    } unit_ctl_t;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
        logic [63:0] high;
    } unit_res_t;

    function automatic logic [63:0] size_mask(input logic [1:0] s);
        logic [63:0] m;
        case (s)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic size_msb(input logic [63:0] v, input logic [1:0] s);
        logic bit_v;
        case (s)
            2'd0:    bit_v = v[7];
            2'd1:    bit_v = v[15];
            2'd2:    bit_v = v[31];
            default: bit_v = v[63];
        endcase
        return bit_v;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [1:0] s);
        logic [63:0] m;
        m = size_mask(s);
        return size_msb(v, s) ? ((v & m) | ~m) : (v & m);
    endfunction

endpackage

// File: rtl/iralu_fifo.sv
// ----------------------------------------------------------------------------
// iralu_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module iralu_fifo #(
    parameter int DEPTH = iralu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  iralu_pkg::dec_t din,
    input  logic            pop,
    output iralu_pkg::dec_t dout,
    output logic            full,
    output logic            empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    iralu_pkg::dec_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign dout  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/iralu_front.sv
// ----------------------------------------------------------------------------
// iralu_front
// Accepts input words, masks operands and settles status and unit class.
// ----------------------------------------------------------------------------
module iralu_front #(
    parameter int DATA_WIDTH = iralu_pkg::DATA_WIDTH_DEF
) (
    input  logic            s_valid,
    output logic            s_ready,
    input  iralu_pkg::in_t  s_data,
    input  logic            q_full,
    output logic            q_push,
    output iralu_pkg::dec_t dec
);
    localparam logic [6:0] WLIM = 7'(DATA_WIDTH);

    logic [1:0]  ss, ds;
    logic [63:0] sm, a, b, c;
    logic [6:0]  ss_bits, ds_bits;
    logic        same, bool_dst;
    iralu_pkg::op_e     op;
    iralu_pkg::status_e st;
    iralu_pkg::kind_e   kind;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        ss       = s_data.src_size;
        ds       = s_data.dst_size;
        op       = iralu_pkg::op_e'(s_data.action);
        sm       = iralu_pkg::size_mask(ss);
        a        = s_data.operand_a & sm;
        b        = s_data.operand_b & sm;
        c        = s_data.operand_c & sm;
        ss_bits  = 7'd8 << ss;
        ds_bits  = 7'd8 << ds;
        same     = (ds == ss);
        bool_dst = (ds == 2'd0);
        st       = iralu_pkg::ST_OK;
        kind     = iralu_pkg::K_SIMPLE;

        if (ss_bits > WLIM || ds_bits > WLIM) begin
            st = iralu_pkg::ST_SIZE;
        end else begin
            case (op)
                iralu_pkg::OP_UCARRY, iralu_pkg::OP_SCARRY, iralu_pkg::OP_PARITY,
                iralu_pkg::OP_EQ, iralu_pkg::OP_ULESS, iralu_pkg::OP_SLESS,
                iralu_pkg::OP_SMULOVF: begin
                    if (!bool_dst) begin
                        st = iralu_pkg::ST_SIZE;
                    end else if (op == iralu_pkg::OP_SMULOVF) begin
                        kind = iralu_pkg::K_MUL;
                    end
                end
                iralu_pkg::OP_TRUNC: begin
                    if (!(ds < ss)) st = iralu_pkg::ST_SIZE;
                end
                iralu_pkg::OP_SEXT, iralu_pkg::OP_ZEXT: begin
                    if (!(ds > ss)) st = iralu_pkg::ST_SIZE;
                end
                iralu_pkg::OP_CJUMP: begin
                    if (ss != 2'd0) st = iralu_pkg::ST_SIZE;
                    else if (a > 64'd1) st = iralu_pkg::ST_COND;
                end
                iralu_pkg::OP_CNEG: begin
                    if (ss != 2'd0 || ds != 2'd0) st = iralu_pkg::ST_SIZE;
                    else if (a > 64'd1) st = iralu_pkg::ST_COND;
                end
                iralu_pkg::OP_SMUL, iralu_pkg::OP_UMUL, iralu_pkg::OP_WMUL: begin
                    if (!same) st = iralu_pkg::ST_SIZE;
                    else kind = iralu_pkg::K_MUL;
                end
                iralu_pkg::OP_UDIV, iralu_pkg::OP_SDIV, iralu_pkg::OP_SREM,
                iralu_pkg::OP_UREM: begin
                    if (!same) st = iralu_pkg::ST_SIZE;
                    else if (b == 64'd0) st = iralu_pkg::ST_DIV0;
                    else kind = iralu_pkg::K_DIV;
                end
                iralu_pkg::OP_WDIV, iralu_pkg::OP_WREM: begin
                    if (!same) st = iralu_pkg::ST_SIZE;
                    else if (c == 64'd0) st = iralu_pkg::ST_DIV0;
                    else kind = iralu_pkg::K_DIV;
                end
                default: begin
                    if (!same) st = iralu_pkg::ST_SIZE;
                end
            endcase
        end

        dec.op   = op;
        dec.ss   = ss;
        dec.ds   = ds;
        dec.st   = st;
        dec.kind = kind;
        dec.a    = a;
        dec.b    = b;
        dec.c    = c;
        dec.sa   = iralu_pkg::sign_ext(a, ss);
        dec.sb   = iralu_pkg::sign_ext(b, ss);
    end

endmodule

// File: rtl/iralu_mul.sv
// ----------------------------------------------------------------------------
// iralu_mul
// 64x64 multiplier built from one 32x32 multiplier, reused for each partial product.
// ----------------------------------------------------------------------------
module iralu_mul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  iralu_pkg::unit_ctl_t ctl,
    input  iralu_pkg::dec_t      req,
    output iralu_pkg::unit_res_t res
);
    localparam logic [2:0] STEP_FIN = 3'd4;

    iralu_pkg::dec_t req_reg;
    logic [63:0]  x_reg, y_reg, value_reg, high_reg;
    logic [127:0] acc_reg, addend;
    logic [2:0]   step_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  xh, yh;
    logic [63:0]  prod, pl, ph, ph_c, dm, val_n, high_n;
    logic         ovf;

    always_comb begin
        xh = step_reg[0] ? x_reg[63:32] : 32'(x_reg & iralu_pkg::LOW32_MASK);
        yh = step_reg[1] ? y_reg[63:32] : 32'(y_reg & iralu_pkg::LOW32_MASK);
        prod = xh * yh;
        case (step_reg[1:0])
            2'd0:    addend = {64'd0, prod};
            2'd3:    addend = {prod, 64'd0};
            default: addend = {32'd0, prod, 32'd0};
        endcase

        // Signed high half: subtract the cross terms of negative operands
        pl   = acc_reg[63:0];
        ph   = acc_reg[127:64];
        ph_c = ph - (x_reg[63] ? y_reg : 64'd0) - (y_reg[63] ? x_reg : 64'd0);
        ovf  = (iralu_pkg::sign_ext(pl, req_reg.ss) != pl) || (ph_c != {64{pl[63]}});
        dm   = iralu_pkg::size_mask(req_reg.ds);
        case (req_reg.op)
            iralu_pkg::OP_SMULOVF: begin
                val_n  = {63'd0, ovf};
                high_n = 64'd0;
            end
            iralu_pkg::OP_WMUL: begin
                val_n  = pl;
                high_n = ph;
            end
            default: begin
                val_n  = pl;
                high_n = 64'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (ctl.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_FIN) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 3'd1;
            end else if (ctl.ack) begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            req_reg <= req;
            x_reg   <= (req.op == iralu_pkg::OP_SMULOVF) ? req.sa : req.a;
            y_reg   <= (req.op == iralu_pkg::OP_SMULOVF) ? req.sb : req.b;
            acc_reg <= '0;
        end else if (busy_reg && step_reg != STEP_FIN) begin
            acc_reg <= acc_reg + addend;
        end
        if (busy_reg && step_reg == STEP_FIN) begin
            value_reg <= val_n & dm;
            high_reg  <= high_n & dm;
        end
    end

    assign res.done  = done_reg;
    assign res.value = value_reg;
    assign res.high  = high_reg;

endmodule

// File: rtl/iralu_div.sv
// ----------------------------------------------------------------------------
// iralu_div
// Restoring divider, one quotient bit per cycle, 64 or 128 dividend bits.
// ----------------------------------------------------------------------------
module iralu_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  iralu_pkg::unit_ctl_t ctl,
    input  iralu_pkg::dec_t      req,
    output iralu_pkg::unit_res_t res
);
    iralu_pkg::dec_t req_reg;
    logic [127:0] dvd_reg;
    logic [63:0]  rem_reg, quo_reg, d_reg, value_reg;
    logic [7:0]   cnt_reg;
    logic         busy_reg, fin_reg, done_reg, na_reg, nb_reg;
    logic         is_signed, is_wide, na, nb, ge;
    logic [63:0]  ma, mb, rem_sh, rem_n, q_f, r_f, val_n;

    always_comb begin
        is_signed = (req.op == iralu_pkg::OP_SDIV) || (req.op == iralu_pkg::OP_SREM);
        is_wide   = (req.op == iralu_pkg::OP_WDIV) || (req.op == iralu_pkg::OP_WREM);
        na        = is_signed && req.sa[63];
        nb        = is_signed && req.sb[63];
        ma        = is_signed ? (na ? 64'd0 - req.sa : req.sa) : req.a;
        mb        = is_signed ? (nb ? 64'd0 - req.sb : req.sb) : req.b;

        // Shift in the next dividend bit, subtract when the divisor fits
        rem_sh = {rem_reg[62:0], dvd_reg[127]};
        ge     = rem_reg[63] || (rem_sh >= d_reg);
        rem_n  = ge ? rem_sh - d_reg : rem_sh;

        q_f = (na_reg != nb_reg) ? 64'd0 - quo_reg : quo_reg;
        r_f = na_reg ? 64'd0 - rem_reg : rem_reg;
        case (req_reg.op)
            iralu_pkg::OP_UDIV, iralu_pkg::OP_SDIV, iralu_pkg::OP_WDIV: val_n = q_f;
            default: val_n = r_f;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (ctl.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= is_wide ? 8'd128 : 8'd64;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end else if (ctl.ack) begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            req_reg <= req;
            dvd_reg <= is_wide ? {req.a, req.b} : {ma, 64'd0};
            d_reg   <= is_wide ? req.c : mb;
            na_reg  <= na;
            nb_reg  <= nb;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[126:0], 1'b0};
            rem_reg <= rem_n;
            quo_reg <= {quo_reg[62:0], ge};
        end
        if (fin_reg) begin
            value_reg <= val_n & iralu_pkg::size_mask(req_reg.ds);
        end
    end

    assign res.done  = done_reg;
    assign res.value = value_reg;
    assign res.high  = 64'd0;

endmodule

// File: rtl/iralu_back.sv
// ----------------------------------------------------------------------------
// iralu_back
// Executes queued words: combinational ALU, multiply and divide units, output
// register.
// ----------------------------------------------------------------------------
module iralu_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  iralu_pkg::dec_t head,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output iralu_pkg::out_t m_data
);
    iralu_pkg::be_state_e state_reg, state_next;
    iralu_pkg::unit_ctl_t mul_ctl, div_ctl;
    iralu_pkg::unit_res_t mul_res, div_res;
    iralu_pkg::out_t      out_simple, out_next, m_data_reg;
    logic                 m_valid_reg, out_free, load;
    logic [63:0]          sm, dm, val, sum;
    logic [5:0]           amt;
    logic                 jmp;

    iralu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .req     (head),
        .res     (mul_res)
    );

    iralu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .req     (head),
        .res     (div_res)
    );

    // Combinational results of the simple operations
    always_comb begin
        sm  = iralu_pkg::size_mask(head.ss);
        dm  = iralu_pkg::size_mask(head.ds);
        sum = head.a + head.b;
        amt = (head.b >= 64'd63) ? 6'd63 : head.b[5:0];
        val = head.a;
        jmp = 1'b0;
        case (head.op)
            iralu_pkg::OP_ADD: val = sum;
            iralu_pkg::OP_SUB: val = head.a - head.b;
            iralu_pkg::OP_XOR: val = head.a ^ head.b;
            iralu_pkg::OP_AND: val = head.a & head.b;
            iralu_pkg::OP_OR:  val = head.a | head.b;
            iralu_pkg::OP_SHL: val = (head.b >= 64'd64) ? 64'd0 : head.a << head.b[5:0];
            iralu_pkg::OP_SHR: val = (head.b >= 64'd64) ? 64'd0 : head.a >> head.b[5:0];
            iralu_pkg::OP_SAR: val = $signed(head.sa) >>> amt;
            iralu_pkg::OP_UCARRY: val = {63'd0, head.a > (sm - head.b)};
            iralu_pkg::OP_SCARRY: begin
                val = {63'd0,
                       (iralu_pkg::size_msb(head.a, head.ss) ==
                        iralu_pkg::size_msb(head.b, head.ss)) &&
                       (iralu_pkg::size_msb(head.a, head.ss) !=
                        iralu_pkg::size_msb(sum, head.ss))};
            end
            iralu_pkg::OP_PARITY: val = {63'd0, ~^head.a};
            iralu_pkg::OP_EQ:     val = {63'd0, head.a == head.b};
            iralu_pkg::OP_NOT:    val = ~head.a;
            iralu_pkg::OP_NEG:    val = 64'd0 - head.a;
            iralu_pkg::OP_ULESS:  val = {63'd0, head.a < head.b};
            iralu_pkg::OP_SLESS:  val = {63'd0, $signed(head.sa) < $signed(head.sb)};
            iralu_pkg::OP_CJUMP: begin
                val = 64'd0;
                jmp = head.a[0];
            end
            iralu_pkg::OP_SEXT:   val = head.sa;
            iralu_pkg::OP_CNEG:   val = head.a ^ 64'd1;
            default:              val = head.a;
        endcase
        // Drop the result of any word that failed its checks
        if (head.st != iralu_pkg::ST_OK) begin
            val = 64'd0;
            jmp = 1'b0;
        end
        out_simple.result_value = val & dm;
        out_simple.result_upper = 64'd0;
        out_simple.take_jump    = jmp;
        out_simple.status       = head.st;
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        q_pop         = 1'b0;
        load          = 1'b0;
        mul_ctl       = '0;
        div_ctl       = '0;
        out_next      = out_simple;
        case (state_reg)
            iralu_pkg::BE_IDLE: begin
                if (!q_empty) begin
                    case (head.kind)
                        iralu_pkg::K_MUL: begin
                            mul_ctl.start = 1'b1;
                            q_pop         = 1'b1;
                            state_next    = iralu_pkg::BE_MUL;
                        end
                        iralu_pkg::K_DIV: begin
                            div_ctl.start = 1'b1;
                            q_pop         = 1'b1;
                            state_next    = iralu_pkg::BE_DIV;
                        end
                        default: begin
                            if (out_free) begin
                                load  = 1'b1;
                                q_pop = 1'b1;
                            end
                        end
                    endcase
                end
            end
            iralu_pkg::BE_MUL: begin
                out_next.result_value = mul_res.value;
                out_next.result_upper = mul_res.high;
                out_next.take_jump    = 1'b0;
                out_next.status       = iralu_pkg::ST_OK;
                if (mul_res.done && out_free) begin
                    load        = 1'b1;
                    mul_ctl.ack = 1'b1;
                    state_next  = iralu_pkg::BE_IDLE;
                end
            end
            iralu_pkg::BE_DIV: begin
                out_next.result_value = div_res.value;
                out_next.result_upper = div_res.high;
                out_next.take_jump    = 1'b0;
                out_next.status       = iralu_pkg::ST_OK;
                if (div_res.done && out_free) begin
                    load        = 1'b1;
                    div_ctl.ack = 1'b1;
                    state_next  = iralu_pkg::BE_IDLE;
                end
            end
            default: state_next = iralu_pkg::BE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= iralu_pkg::BE_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/ir_integer_alu_core.sv
// ----------------------------------------------------------------------------
// ir_integer_alu_core
// Integer ALU for intermediate-language operations with wide mul and div.
// ----------------------------------------------------------------------------
// Usage: present one operation word on s_data with s_valid; it is taken when
// s_valid and s_ready are both high. Each word yields exactly one result word
// on m_data, held with m_valid until m_ready, in the order the words came in.
// Simple operations pass from the queue to the output register; multiplies
// use one 32x32 multiplier four times, and 64-bit and 128/64 divides take one
// quotient bit a cycle in the restoring divider.
// Throughput: one word per cycle for simple operations while the receiver
// takes results; a multiply or divide holds the execute side until its result
// is loaded into the output register.
// A queue of QUEUE_DEPTH words lets the input side keep accepting while the
// execute side works or the receiver stalls; s_ready drops only when it fills.
// Reset (aresetn low, synchronous) empties the queue, idles both units and
// clears m_valid; s_ready is high right after reset.
// ----------------------------------------------------------------------------
module ir_integer_alu_core #(
    parameter int DATA_WIDTH  = iralu_pkg::DATA_WIDTH_DEF,
    parameter int QUEUE_DEPTH = iralu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  iralu_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output iralu_pkg::out_t m_data
);
    iralu_pkg::dec_t dec, head;
    logic            q_push, q_pop, q_full, q_empty;

    iralu_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .dec     (dec)
    );

    iralu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (dec),
        .pop     (q_pop),
        .dout    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    iralu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/iralu_checker.sv
// ----------------------------------------------------------------------------
// iralu_checker
// Port-level checks of the integer ALU core, bound to the top level.
// ----------------------------------------------------------------------------
`include "ir_integer_alu_core_defines.svh"

module iralu_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input iralu_pkg::in_t  s_data,
    input logic            m_valid,
    input logic            m_ready,
    input iralu_pkg::out_t m_data
);
    // Hold a stalled result word
    `IRALU_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word changed while stalled")

    // A failed word carries no result
    `IRALU_ASSERT(a_err_zero, m_valid && m_data.status != iralu_pkg::ST_OK |-> m_data.result_value == 64'd0 && m_data.result_upper == 64'd0 && !m_data.take_jump, "failed word carries data")

    // Reset clears the result side and opens the input side
    `IRALU_ASSERT_RST(a_rst_mvalid, !aresetn |=> !m_valid, "m_valid set after reset")
    `IRALU_ASSERT_RST(a_rst_sready, !aresetn |=> s_ready, "s_ready low after reset")

endmodule

bind ir_integer_alu_core iralu_checker u_iralu_checker (.*);

// File: verif/tb_ir_integer_alu_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_integer_alu_core
// Drives operation words into the integer ALU core with random gaps and
// stalls on both sides, predicts every result word and checks it in order.
// ----------------------------------------------------------------------------
module tb_ir_integer_alu_core;

    localparam int WATCHDOG_LIMIT = 20000;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    iralu_pkg::in_t  s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    iralu_pkg::out_t m_data;

    int   mismatch_cnt = 0;
    logic stim_done = 1'b0;

    always #2 aclk = ~aclk;

    ir_integer_alu_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        mismatch_cnt++;
    endtask

    function automatic logic [63:0] msk(input logic [1:0] s);
        return (s == 2'd3) ? '1 : ((64'd1 << (8 << s)) - 64'd1);
    endfunction

    function automatic logic [63:0] sx(input logic [63:0] v, input logic [1:0] s);
        logic [63:0] m;
        m = msk(s);
        v = v & m;
        return v[(8 << s) - 1] ? (v | ~m) : v;
    endfunction

    // Compute the result word for one operation word
    function automatic iralu_pkg::out_t alu_result(input iralu_pkg::in_t w);
        iralu_pkg::out_t     r;
        logic [63:0]         sm, a, b, c, sa, sb, v, h, q, rm, ps;
        logic [127:0]        p;
        logic signed [127:0] sp;
        logic [127:0]        num;
        logic                same, bo, jmp;
        iralu_pkg::status_e  st;
        int                  sbits;
        sm = msk(w.src_size);
        a = w.operand_a & sm; b = w.operand_b & sm; c = w.operand_c & sm;
        sa = sx(a, w.src_size); sb = sx(b, w.src_size);
        sbits = 8 << w.src_size;
        same = (w.src_size == w.dst_size); bo = (w.dst_size == 2'd0);
        v = '0; h = '0; jmp = 1'b0; st = iralu_pkg::ST_OK;
        case (iralu_pkg::op_e'(w.action))
            iralu_pkg::OP_MOVE: if (!same) st = iralu_pkg::ST_SIZE; else v = a;
            iralu_pkg::OP_ADD:  if (!same) st = iralu_pkg::ST_SIZE; else v = a + b;
            iralu_pkg::OP_SUB:  if (!same) st = iralu_pkg::ST_SIZE; else v = a - b;
            iralu_pkg::OP_XOR:  if (!same) st = iralu_pkg::ST_SIZE; else v = a ^ b;
            iralu_pkg::OP_AND:  if (!same) st = iralu_pkg::ST_SIZE; else v = a & b;
            iralu_pkg::OP_OR:   if (!same) st = iralu_pkg::ST_SIZE; else v = a | b;
            iralu_pkg::OP_SHL:
                if (!same) st = iralu_pkg::ST_SIZE; else v = (b >= 64) ? '0 : a << b;
            iralu_pkg::OP_UCARRY:
                if (!bo) st = iralu_pkg::ST_SIZE; else v = 64'(a > sm - b);
            iralu_pkg::OP_SCARRY: begin
                ps = a + b;
                if (!bo) st = iralu_pkg::ST_SIZE;
                else v = 64'((a[sbits-1] == b[sbits-1]) && (a[sbits-1] != ps[sbits-1]));
            end
            iralu_pkg::OP_TRUNC:
                if (!(w.dst_size < w.src_size)) st = iralu_pkg::ST_SIZE; else v = a;
            iralu_pkg::OP_PARITY: if (!bo) st = iralu_pkg::ST_SIZE; else v = 64'(~^a);
            iralu_pkg::OP_EQ:     if (!bo) st = iralu_pkg::ST_SIZE; else v = 64'(a == b);
            iralu_pkg::OP_NOT:    if (!same) st = iralu_pkg::ST_SIZE; else v = ~a;
            iralu_pkg::OP_NEG:    if (!same) st = iralu_pkg::ST_SIZE; else v = -a;
            iralu_pkg::OP_SHR:
                if (!same) st = iralu_pkg::ST_SIZE; else v = (b >= 64) ? '0 : a >> b;
            iralu_pkg::OP_SAR: if (!same) st = iralu_pkg::ST_SIZE;
                    else v = $signed(sa) >>> ((b >= 63) ? 63 : b[5:0]);
            iralu_pkg::OP_ULESS: if (!bo) st = iralu_pkg::ST_SIZE; else v = 64'(a < b);
            iralu_pkg::OP_SLESS:
                if (!bo) st = iralu_pkg::ST_SIZE; else v = 64'($signed(sa) < $signed(sb));
            iralu_pkg::OP_CJUMP: if (w.src_size != 2'd0) st = iralu_pkg::ST_SIZE;
                      else if (a > 1) st = iralu_pkg::ST_COND; else jmp = a[0];
            iralu_pkg::OP_SEXT:
                if (!(w.dst_size > w.src_size)) st = iralu_pkg::ST_SIZE; else v = sa;
            iralu_pkg::OP_ZEXT:
                if (!(w.dst_size > w.src_size)) st = iralu_pkg::ST_SIZE; else v = a;
            iralu_pkg::OP_SMUL, iralu_pkg::OP_UMUL:
                if (!same) st = iralu_pkg::ST_SIZE; else v = a * b;
            iralu_pkg::OP_SMULOVF: begin
                sp = $signed({{64{sa[63]}}, sa}) * $signed({{64{sb[63]}}, sb});
                if (!bo) st = iralu_pkg::ST_SIZE;
                else v = 64'((sp[127:64] != {64{sp[63]}}) ||
                             (sx(sp[63:0], w.src_size) != sp[63:0]));
            end
            iralu_pkg::OP_UDIV, iralu_pkg::OP_UREM:
                if (!same) st = iralu_pkg::ST_SIZE;
                else if (b == 0) st = iralu_pkg::ST_DIV0;
                else v = (w.action == iralu_pkg::OP_UDIV) ? a / b : a % b;
            iralu_pkg::OP_SDIV, iralu_pkg::OP_SREM: begin
                if (!same) st = iralu_pkg::ST_SIZE;
                else if (b == 0) st = iralu_pkg::ST_DIV0;
                else begin
                    q = sa[63] ? -sa : sa; rm = sb[63] ? -sb : sb;
                    if (w.action == iralu_pkg::OP_SDIV) begin
                        v = q / rm;
                        if (sa[63] != sb[63]) v = -v;
                    end else begin
                        v = q % rm;
                        if (sa[63]) v = -v;
                    end
                end
            end
            iralu_pkg::OP_WDIV, iralu_pkg::OP_WREM: begin
                if (!same) st = iralu_pkg::ST_SIZE;
                else if (c == 0) st = iralu_pkg::ST_DIV0;
                else begin
                    num = {a, b};
                    v = (w.action == iralu_pkg::OP_WDIV) ? 64'(num / {64'd0, c})
                                                         : 64'(num % {64'd0, c});
                end
            end
            iralu_pkg::OP_CNEG:
                if (w.src_size != 2'd0 || w.dst_size != 2'd0) st = iralu_pkg::ST_SIZE;
                else if (a > 1) st = iralu_pkg::ST_COND; else v = a ^ 64'd1;
            default: begin
                p = {64'd0, a} * {64'd0, b};
                if (!same) st = iralu_pkg::ST_SIZE;
                else begin v = p[63:0]; h = p[127:64]; end
            end
        endcase
        if (st != iralu_pkg::ST_OK) begin v = '0; h = '0; jmp = 1'b0; end
        r.result_value = v & msk(w.dst_size);
        r.result_upper = h & msk(w.dst_size);
        r.take_jump    = jmp;
        r.status       = st;
        return r;
    endfunction

    class alu_scoreboard;
        iralu_pkg::out_t pending[$];
        function void note_word(iralu_pkg::in_t w);
            pending.push_back(alu_result(w));
        endfunction
        task check_word(iralu_pkg::out_t got);
            iralu_pkg::out_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", got.result_value, '0);
                return;
            end
            want = pending.pop_front();
            if (got.result_value !== want.result_value)
                report_mismatch("result_value", got.result_value, want.result_value);
            if (got.result_upper !== want.result_upper)
                report_mismatch("result_upper", got.result_upper, want.result_upper);
            if (got.take_jump !== want.take_jump)
                report_mismatch("take_jump", 64'(got.take_jump), 64'(want.take_jump));
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
        endtask
    endclass

    alu_scoreboard sb = new();

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        int k;
        v = {$urandom(), $urandom()};
        k = $urandom_range(0, 9);
        if (k == 0) v = '0;
        else if (k == 1) v = '1;
        else if (k == 2) v = 64'($urandom_range(0, 3));
        else if (k == 3) v = 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
        return v;
    endfunction

    task automatic send_word(input iralu_pkg::in_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(w);
    endtask

    task automatic send_gap();
        int n;
        n = gap_len();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Directed words cover every operation first, at the widest size apart from OP_CJUMP and OP_CNEG
    task automatic run_stimulus();
        iralu_pkg::in_t w;
        logic [1:0] ss;
        for (int op = 0; op < 32; op++) begin
            w.action = op[4:0];
            w.src_size = 2'd3; w.dst_size = 2'd3;
            w.operand_a = 64'h8000_0000_0000_0000;
            w.operand_b = '1; w.operand_c = 64'd3;
            if (op == iralu_pkg::OP_CJUMP || op == iralu_pkg::OP_CNEG) begin
                w.src_size = 2'd0; w.dst_size = 2'd0; w.operand_a = 64'd1;
            end
            send_word(w);
        end
        for (int i = 0; i < 650; i++) begin
            w.action = 5'($urandom_range(0, 31));
            ss = 2'($urandom_range(0, 3));
            w.src_size = ss;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: w.dst_size = ss;
                4, 5: w.dst_size = 2'd0;
                6: w.dst_size = 2'($urandom_range(ss, 3));
                7: w.dst_size = 2'($urandom_range(0, ss));
                default: w.dst_size = 2'($urandom_range(0, 3));
            endcase
            w.operand_a = rand64();
            w.operand_b = rand64();
            w.operand_c = rand64();
            if ($urandom_range(0, 3) == 0)
                w.operand_b[63:6] = $urandom_range(0, 1) ? '0 : w.operand_b[63:6];
            if ((w.action == iralu_pkg::OP_CJUMP || w.action == iralu_pkg::OP_CNEG) &&
                $urandom_range(0, 3) != 0)
                w.operand_a = 64'($urandom_range(0, 1));
            send_word(w);
            if (i == 300) begin
                // hold until the result queue drains
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.pending.size() != 0) @(posedge aclk);
            end else if (i < 100 || i > 200) begin
                send_gap();
            end
        end
        s_valid <= 1'b0;
        stim_done <= 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_stimulus();
    end

    // Receiver: random stalls, check at each accepting edge
    initial begin : receiver
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            n = gap_len();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_word(m_data);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        @(posedge aclk);
        while (!(stim_done && sb.pending.size() == 0)) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("ir_integer_alu_core test failed");
                $finish;
            end
        end
        repeat (200) @(posedge aclk);
        if (mismatch_cnt == 0 && sb.pending.size() == 0)
            $display("ir_integer_alu_core test passed");
        else
            $display("ir_integer_alu_core test failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/iralu_pkg.sv
rtl/iralu_fifo.sv
rtl/iralu_front.sv
rtl/iralu_mul.sv
rtl/iralu_div.sv
rtl/iralu_back.sv
rtl/ir_integer_alu_core.sv
rtl/iralu_checker.sv
verif/tb_ir_integer_alu_core.sv
